// ===== hw/rtl/ssw_pkg.sv =====
// ----------------------------------------------------------------------------
// ssw_pkg: shared types and constants of the stencil sweep core
// Word layouts of both channels, size register indexes and limits, and the
// divide-by-ten helper for small operands.
// ----------------------------------------------------------------------------
package ssw_pkg;

   localparam int SIZE_W   = 7;
   localparam int SAMPLE_W = 32;

   localparam int DEF_MAX_X = 64;
   localparam int DEF_MAX_Y = 64;
   localparam int DEF_MAX_Z = 64;

   localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SIZE_Z = 2'd2;

   localparam logic KIND_VOXEL = 1'b0;
   localparam logic KIND_FLUSH = 1'b1;

   // floor(x / 10) is floor(x * RECIP10 / 2^23) for every x below 2^22
   localparam logic [19:0] RECIP10 = 20'd838861;

   typedef struct packed {
      logic                       kind;
      logic signed [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] result;
      logic                       last;
   } rsp_type;

   function automatic logic [16:0] div10(input logic [19:0] x);
      logic [39:0] prod;
      prod = x * RECIP10;
      return prod[39:23];
   endfunction

endpackage

// ===== hw/rtl/seven_point_stencil_sweep_core.sv =====
// ----------------------------------------------------------------------------
// seven_point_stencil_sweep_core: streaming seven-point 3D Jacobi stencil
// Voxels enter in raster order (z fastest); each output is 0.4 * center plus
// 0.1 * the six neighbors, faces mirrored from the center, Q16.16, rounded.
//
//   channel  ports                               word
//   req      req_valid / req_ready / req_payload  kind, sample
//   rsp      rsp_valid / rsp_ready / rsp_payload  result, last
//   csr      csr_we / csr_index / csr_wdata       size_x, size_y, size_z
//
// One word per cycle sustained while rsp is ready; an output word passes the
// sum, divide and saturate stages after the req word completing its window.
// In stream terms outputs lag one plane plus one voxel; flush words drain.
// The neighbor window is a chain of delay segments in RAM, needing no clear.
// Reset is synchronous; a rsp stall fills the three stages, then req_ready
// drops.
// ----------------------------------------------------------------------------
module seven_point_stencil_sweep_core #(
   parameter int MAX_X = ssw_pkg::DEF_MAX_X,
   parameter int MAX_Y = ssw_pkg::DEF_MAX_Y,
   parameter int MAX_Z = ssw_pkg::DEF_MAX_Z
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  ssw_pkg::req_type                    req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output ssw_pkg::rsp_type                    rsp_payload,
   input  logic                                csr_we,
   input  logic [ssw_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ssw_pkg::SIZE_W-1:0]          csr_wdata
);

   import ssw_pkg::*;

   localparam int XW  = (MAX_X > 1) ? $clog2(MAX_X) : 1;
   localparam int YW  = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
   localparam int ZW  = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
   localparam int EXW = $clog2(MAX_X + 1);
   localparam int EYW = $clog2(MAX_Y + 1);
   localparam int EZW = $clog2(MAX_Z + 1);
   localparam int PLANE_MAX   = MAX_Y * MAX_Z;
   localparam int PW          = $clog2(PLANE_MAX + 1);
   localparam int ICW         = $clog2(PLANE_MAX + 2);
   localparam int BIG_DEPTH   = (PLANE_MAX - MAX_Z > 1) ? PLANE_MAX - MAX_Z : 1;
   localparam int BW          = $clog2(BIG_DEPTH + 1);
   localparam int SMALL_DEPTH = (MAX_Z - 1 > 1) ? MAX_Z - 1 : 1;
   localparam int SMW         = $clog2(SMALL_DEPTH + 1);

   function automatic logic [31:0] clamp_size(input logic [SIZE_W-1:0] v, input int maxv);
      logic [31:0] r;
      r = 32'(v);
      if (r == 32'd0) begin
         r = 32'd1;
      end else if (r > 32'(maxv)) begin
         r = 32'(maxv);
      end
      return r;
   endfunction

   // size registers, already clamped, and derived segment lengths
   logic [EXW-1:0] eff_x_ff, eff_x_in;
   logic [EYW-1:0] eff_y_ff, eff_y_in;
   logic [EZW-1:0] eff_z_ff, eff_z_in;
   logic [PW-1:0]  plane_ff, plane_in;
   logic [BW-1:0]  big_len_ff, big_len_in;
   logic [SMW-1:0] small_len_ff, small_len_in;
   logic           cfg_hit;

   // stream control
   logic [ICW-1:0] input_count_ff, input_count_in;
   logic [XW-1:0]  out_x_ff, out_x_in;
   logic [YW-1:0]  out_y_ff, out_y_in;
   logic [ZW-1:0]  out_z_ff, out_z_in;
   logic           accept, push, filling, emit, last_now;
   logic           x_has_prev, x_has_next, y_has_prev, y_has_next;
   logic           z_has_prev, z_has_next;
   logic [SAMPLE_W-1:0] val;

   // window taps
   logic [SAMPLE_W-1:0] tap1_ff, center_ff, zm_ff;
   logic [SAMPLE_W-1:0] yp_tap, zp_tap, ym_tap, xm_tap;

   // pipeline
   logic               ready1, ready2, ready3;
   logic               v1_ff, v2_ff, v3_ff;
   logic signed [35:0] num_ff, num_in;
   logic               last1_ff;
   logic               neg2_ff, last2_ff;
   logic [15:0]        qh_ff;
   logic [19:0]        rem_ff;
   logic               neg2_in;
   logic [35:0]        mag;
   logic [34:0]        sum5;
   logic [18:0]        hi;
   logic [16:0]        qh_full;
   logic [18:0]        rh;
   logic [16:0]        ql_full;
   logic [31:0]        qmag;
   rsp_type            rsp_ff, rsp_in;

   always_comb begin
      eff_x_in = eff_x_ff;
      eff_y_in = eff_y_ff;
      eff_z_in = eff_z_ff;
      cfg_hit  = 1'b0;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SIZE_X: begin
               eff_x_in = EXW'(clamp_size(csr_wdata, MAX_X));
               cfg_hit  = 1'b1;
            end
            CSR_SIZE_Y: begin
               eff_y_in = EYW'(clamp_size(csr_wdata, MAX_Y));
               cfg_hit  = 1'b1;
            end
            CSR_SIZE_Z: begin
               eff_z_in = EZW'(clamp_size(csr_wdata, MAX_Z));
               cfg_hit  = 1'b1;
            end
            default: begin
            end
         endcase
      end
      plane_in     = PW'(eff_y_in) * PW'(eff_z_in);
      big_len_in   = BW'(plane_in - PW'(eff_z_in));
      small_len_in = SMW'(eff_z_in - EZW'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_x_ff     <= EXW'(clamp_size(SIZE_RESET, MAX_X));
         eff_y_ff     <= EYW'(clamp_size(SIZE_RESET, MAX_Y));
         eff_z_ff     <= EZW'(clamp_size(SIZE_RESET, MAX_Z));
         plane_ff     <= PW'(clamp_size(SIZE_RESET, MAX_Y) * clamp_size(SIZE_RESET, MAX_Z));
         big_len_ff   <= BW'(clamp_size(SIZE_RESET, MAX_Y) * clamp_size(SIZE_RESET, MAX_Z)
                            - clamp_size(SIZE_RESET, MAX_Z));
         small_len_ff <= SMW'(clamp_size(SIZE_RESET, MAX_Z) - 32'd1);
      end else begin
         eff_x_ff     <= eff_x_in;
         eff_y_ff     <= eff_y_in;
         eff_z_ff     <= eff_z_in;
         plane_ff     <= plane_in;
         big_len_ff   <= big_len_in;
         small_len_ff <= small_len_in;
      end
   end

   assign req_ready = ready1;
   assign accept    = req_valid && req_ready;
   assign val       = (req_payload.kind == KIND_FLUSH) ? '0 : req_payload.sample;
   assign push      = accept && !((req_payload.kind == KIND_FLUSH) && (input_count_ff == '0));
   assign filling   = 32'(input_count_ff) <= 32'(plane_ff);
   assign emit      = push && !filling;

   assign x_has_prev = out_x_ff != '0;
   assign y_has_prev = out_y_ff != '0;
   assign z_has_prev = out_z_ff != '0;
   assign x_has_next = (32'(out_x_ff) + 32'd1) < 32'(eff_x_ff);
   assign y_has_next = (32'(out_y_ff) + 32'd1) < 32'(eff_y_ff);
   assign z_has_next = (32'(out_z_ff) + 32'd1) < 32'(eff_z_ff);
   assign last_now   = !x_has_next && !y_has_next && !z_has_next;

   always_comb begin
      input_count_in = input_count_ff;
      out_x_in = out_x_ff;
      out_y_in = out_y_ff;
      out_z_in = out_z_ff;
      if (cfg_hit) begin
         input_count_in = '0;
         out_x_in = '0;
         out_y_in = '0;
         out_z_in = '0;
      end else if (push && filling) begin
         input_count_in = input_count_ff + ICW'(1);
      end else if (emit) begin
         if (last_now) begin
            input_count_in = '0;
            out_x_in = '0;
            out_y_in = '0;
            out_z_in = '0;
         end else if (z_has_next) begin
            out_z_in = out_z_ff + ZW'(1);
         end else begin
            out_z_in = '0;
            if (y_has_next) begin
               out_y_in = out_y_ff + YW'(1);
            end else begin
               out_y_in = '0;
               out_x_in = out_x_ff + XW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         input_count_ff <= '0;
         out_x_ff <= '0;
         out_y_ff <= '0;
         out_z_ff <= '0;
      end else begin
         input_count_ff <= input_count_in;
         out_x_ff <= out_x_in;
         out_y_ff <= out_y_in;
         out_z_ff <= out_z_in;
      end
   end

   // window: newest -> +y -> +z -> center -> -z -> -y -> -x
   always_ff @(posedge clock) begin
      if (push) begin
         tap1_ff   <= val;
         center_ff <= zp_tap;
         zm_ff     <= center_ff;
      end
   end

   ssw_delay #(.WIDTH(SAMPLE_W), .DEPTH(BIG_DEPTH)) u_seg_yp (
      .clock (clock), .reset (reset), .clear (cfg_hit), .shift (push),
      .len (big_len_ff), .din (tap1_ff), .dout (yp_tap)
   );

   ssw_delay #(.WIDTH(SAMPLE_W), .DEPTH(SMALL_DEPTH)) u_seg_zp (
      .clock (clock), .reset (reset), .clear (cfg_hit), .shift (push),
      .len (small_len_ff), .din (yp_tap), .dout (zp_tap)
   );

   ssw_delay #(.WIDTH(SAMPLE_W), .DEPTH(SMALL_DEPTH)) u_seg_ym (
      .clock (clock), .reset (reset), .clear (cfg_hit), .shift (push),
      .len (small_len_ff), .din (zm_ff), .dout (ym_tap)
   );

   ssw_delay #(.WIDTH(SAMPLE_W), .DEPTH(BIG_DEPTH)) u_seg_xm (
      .clock (clock), .reset (reset), .clear (cfg_hit), .shift (push),
      .len (big_len_ff), .din (ym_tap), .dout (xm_tap)
   );

   // stage 1: neighborhood sum
   always_comb begin
      logic signed [35:0] c_ext;
      c_ext  = 36'(signed'(center_ff));
      num_in = (c_ext <<< 2)
             + (z_has_prev ? 36'(signed'(zm_ff))   : c_ext)
             + (z_has_next ? 36'(signed'(zp_tap))  : c_ext)
             + (y_has_prev ? 36'(signed'(ym_tap))  : c_ext)
             + (y_has_next ? 36'(signed'(yp_tap))  : c_ext)
             + (x_has_prev ? 36'(signed'(xm_tap))  : c_ext)
             + (x_has_next ? 36'(signed'(tap1_ff)) : c_ext);
   end

   assign ready3 = !v3_ff || rsp_ready;
   assign ready2 = !v2_ff || ready3;
   assign ready1 = !v1_ff || ready2;

   // stage 2: magnitude, round bias, divide the upper part by ten
   always_comb begin
      neg2_in = num_ff[35];
      mag     = neg2_in ? 36'(-num_ff) : 36'(num_ff);
      sum5    = mag[34:0] + 35'd5;
      hi      = sum5[34:16];
      qh_full = div10({1'b0, hi});
      rh      = hi - (19'(qh_full) * 19'd10);
   end

   // stage 3: divide the remainder part, sign and saturate
   always_comb begin
      ql_full = div10(rem_ff);
      qmag    = {qh_ff, ql_full[15:0]};
      rsp_in.last = last2_ff;
      if (!neg2_ff) begin
         rsp_in.result = qmag[31] ? 32'sh7FFF_FFFF : signed'(qmag);
      end else begin
         rsp_in.result = (qmag > 32'h8000_0000) ? 32'sh8000_0000 : signed'(-qmag);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready1) begin
            v1_ff <= emit;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
         if (ready3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ready1 && emit) begin
         num_ff   <= num_in;
         last1_ff <= last_now;
      end
      if (ready2 && v1_ff) begin
         neg2_ff  <= neg2_in;
         qh_ff    <= qh_full[15:0];
         rem_ff   <= {rh[3:0], sum5[15:0]};
         last2_ff <= last1_ff;
      end
      if (ready3 && v2_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = v3_ff;
   assign rsp_payload = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      32'(input_count_ff) <= 32'(plane_ff) + 32'd1)
      else $error("input count past one plane plus one");

   a_coord_bound: assert property (@(posedge clock) disable iff (reset)
      (32'(out_x_ff) < 32'(eff_x_ff)) && (32'(out_y_ff) < 32'(eff_y_ff))
      && (32'(out_z_ff) < 32'(eff_z_ff)))
      else $error("output coordinate outside volume");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      emit && last_now |=> input_count_ff == '0 && out_x_ff == '0
      && out_y_ff == '0 && out_z_ff == '0)
      else $error("sweep did not restart after last voxel");

   a_stage1_holds: assert property (@(posedge clock) disable iff (reset)
      v1_ff && !ready2 |=> v1_ff && $stable(num_ff) && $stable(last1_ff))
      else $error("sum stage lost its word under stall");

endmodule

// ===== hw/rtl/ssw_ram.sv =====
// ----------------------------------------------------------------------------
// ssw_ram: generic simple dual-port RAM
// One write port and one read port, registered read, old data on a
// same-address read and write.
// ----------------------------------------------------------------------------
module ssw_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2
) (
   input  logic                                   clock,
   input  logic                                   wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                       wr_data,
   input  logic                                   rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/ssw_delay.sv =====
// ----------------------------------------------------------------------------
// ssw_delay: run-time length delay segment
// Delays the word stream by len shifts: a wire for zero, a register for one,
// a circular RAM buffer behind its read register for longer lengths.
// ----------------------------------------------------------------------------
module ssw_delay #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear,
   input  logic                         shift,
   input  logic [$clog2(DEPTH+1)-1:0]   len,
   input  logic [WIDTH-1:0]             din,
   output logic [WIDTH-1:0]             dout
);

   localparam int LW = $clog2(DEPTH + 1);
   localparam int RD = (DEPTH > 2) ? DEPTH - 1 : 1;
   localparam int AW = (RD > 1) ? $clog2(RD) : 1;

   logic [AW-1:0]    ptr_ff, ptr_in;
   logic [WIDTH-1:0] stage_ff;
   logic [WIDTH-1:0] ram_rdata;
   logic             wrap;

   always_comb begin
      wrap = ((32'(ptr_ff) + 32'd2) == 32'(len)) || (32'(ptr_ff) == RD - 1);
      ptr_in = ptr_ff;
      if (clear) begin
         ptr_in = '0;
      end else if (shift) begin
         ptr_in = wrap ? '0 : ptr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (shift) begin
         stage_ff <= din;
      end
   end

   ssw_ram #(
      .WIDTH (WIDTH),
      .DEPTH (RD)
   ) u_ram (
      .clock   (clock),
      .wr_en   (shift),
      .wr_addr (ptr_ff),
      .wr_data (din),
      .rd_en   (shift),
      .rd_addr (ptr_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      if (len == LW'(0)) begin
         dout = din;
      end else if (len == LW'(1)) begin
         dout = stage_ff;
      end else begin
         dout = ram_rdata;
      end
   end

   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(ptr_ff) < RD)
      else $error("delay pointer beyond buffer");

endmodule
